// File: hdl/npcq_pkg.sv
// Shared types, widths and register codes for the nearest palette color quantizer.
`timescale 1ns / 1ps
`default_nettype none

package npcq_pkg;

   localparam int PALETTE_SIZE_DEFAULT = 6;
   localparam int CHAN_W = 8;
   localparam int GAIN_W = 10;
   localparam int IDX_W = 3;
   localparam int SQ_W = 2 * CHAN_W;
   localparam int DIST_W = SQ_W + 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 3 * GAIN_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAINS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY0 = 3'd2;

   localparam logic [CSR_DATA_W-1:0] GAINS_RESET = 30'h10040100;
   localparam logic [IDX_W-1:0] COUNT_RESET = 3'd6;

   typedef logic [DIST_W-1:0] dist_type;

   typedef struct packed {
      logic [CHAN_W-1:0] in_red;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  palette_index;
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

endpackage

`default_nettype wire

// File: hdl/npcq_scale.sv
// First pipeline stage: per-channel gain scaling with saturation.
`timescale 1ns / 1ps
`default_nettype none

module npcq_scale
   import npcq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire req_type               in_data,
   input  wire logic [CSR_DATA_W-1:0] gains,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output pixel_type                  out_pixel
);

   function automatic logic [CHAN_W-1:0] scale(input logic [CHAN_W-1:0] value,
                                               input logic [GAIN_W-1:0] gain);
      logic [CHAN_W+GAIN_W-1:0] prod;
      logic [GAIN_W-1:0]        shifted;
      prod = (CHAN_W + GAIN_W)'(value) * (CHAN_W + GAIN_W)'(gain);
      shifted = prod[CHAN_W+GAIN_W-1:CHAN_W];
      scale = (|shifted[GAIN_W-1:CHAN_W]) ? {CHAN_W{1'b1}} : shifted[CHAN_W-1:0];
   endfunction

   logic      valid_ff;
   logic      valid_in;
   pixel_type pixel_ff;
   pixel_type pixel_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      pixel_in.red = scale(in_data.in_red, gains[3*GAIN_W-1:2*GAIN_W]);
      pixel_in.green = scale(in_data.in_green, gains[2*GAIN_W-1:GAIN_W]);
      pixel_in.blue = scale(in_data.in_blue, gains[GAIN_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

`default_nettype wire

// File: hdl/npcq_dist.sv
// Second and third pipeline stages: squared channel differences, then their sums.
`timescale 1ns / 1ps
`default_nettype none

module npcq_dist
   import npcq_pkg::*;
#(
   parameter int PALETTE_SIZE = PALETTE_SIZE_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire pixel_type in_pixel,
   input  wire pixel_type entries [PALETTE_SIZE],
   output logic           out_valid,
   input  wire logic      out_ready,
   output dist_type       out_dist [PALETTE_SIZE]
);

   function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      sq_diff = SQ_W'(d) * SQ_W'(d);
   endfunction

   logic            sq_valid_ff;
   logic            sq_valid_in;
   logic            sq_ready;
   logic [SQ_W-1:0] sq_ff [PALETTE_SIZE][3];
   logic            sum_valid_ff;
   logic            sum_valid_in;
   dist_type        sum_ff [PALETTE_SIZE];

   assign sum_valid_in = sq_ready ? sq_valid_ff : sum_valid_ff;
   assign sq_ready = !sum_valid_ff || out_ready;
   assign in_ready = !sq_valid_ff || sq_ready;
   assign sq_valid_in = in_ready ? in_valid : sq_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         for (int i = 0; i < PALETTE_SIZE; i++) begin
            sq_ff[i][0] <= sq_diff(in_pixel.red, entries[i].red);
            sq_ff[i][1] <= sq_diff(in_pixel.green, entries[i].green);
            sq_ff[i][2] <= sq_diff(in_pixel.blue, entries[i].blue);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sq_ready && sq_valid_ff) begin
         for (int i = 0; i < PALETTE_SIZE; i++) begin
            sum_ff[i] <= DIST_W'(sq_ff[i][0]) + DIST_W'(sq_ff[i][1]) + DIST_W'(sq_ff[i][2]);
         end
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_dist = sum_ff;

endmodule

`default_nettype wire

// File: hdl/npcq_cmp_stage.sv
// One compare stage of the minimum search: tests one palette entry against the best so far.
`timescale 1ns / 1ps
`default_nettype none

module npcq_cmp_stage
   import npcq_pkg::*;
#(
   parameter int PALETTE_SIZE = PALETTE_SIZE_DEFAULT,
   parameter int STAGE = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] count,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [IDX_W-1:0] in_best,
   input  wire dist_type         in_best_dist,
   input  wire dist_type         in_dist [PALETTE_SIZE],
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [IDX_W-1:0]      out_best,
   output dist_type              out_best_dist,
   output dist_type              out_dist [PALETTE_SIZE]
);

   logic             valid_ff;
   logic             valid_in;
   logic             take;
   logic [IDX_W-1:0] best_ff;
   dist_type         best_dist_ff;
   dist_type         dist_ff [PALETTE_SIZE];

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign take = (IDX_W'(STAGE) < count) && (in_dist[STAGE] < in_best_dist);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         best_ff <= take ? IDX_W'(STAGE) : in_best;
         best_dist_ff <= take ? in_dist[STAGE] : in_best_dist;
         dist_ff <= in_dist;
      end
   end

   assign out_valid = valid_ff;
   assign out_best = best_ff;
   assign out_best_dist = best_dist_ff;
   assign out_dist = dist_ff;

endmodule

`default_nettype wire

// File: hdl/nearest_palette_color_quantizer_unit.sv
// Top level of the nearest palette color quantizer: registers, pipeline chain and output stage.
// Usage:
// Pixels enter on the req_ channel (valid/ready) as three 8-bit channels. Each beat is scaled
// by the per-channel gains, compared by squared distance with the palette entries in use, and
// leaves on the rsp_ channel as the index of the nearest entry (first on ties) and its color.
// Registers are written through csr_we, csr_index and csr_wdata, with no read-back,
// and must only change while no pixel is in flight.
// The pipeline has one gain stage, one square stage, one sum stage, PALETTE_SIZE - 1 compare
// stages (one palette entry each) and the output register.
// Throughput is one pixel per cycle while rsp_ready is high; every stage holds its own
// valid bit, so bubbles close up. When the receiver holds rsp_ready low, the output
// beat holds and the stages behind it keep filling; req_ready drops only once every
// stage is occupied. Reset empties the pipeline, sets all gains to 1.0, the entry count
// to six and every palette entry to black.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_quantizer_unit
   import npcq_pkg::*;
#(
   parameter int PALETTE_SIZE = PALETTE_SIZE_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int EW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

   logic [CSR_DATA_W-1:0] gains_ff;
   logic [IDX_W-1:0]      count_ff;
   pixel_type             entries_ff [PALETTE_SIZE];
   logic [IDX_W-1:0]      count_used;

   logic                  scale_valid;
   logic                  scale_ready;
   pixel_type             scale_pixel;

   logic                  chain_valid [PALETTE_SIZE];
   logic                  chain_ready [PALETTE_SIZE];
   logic [IDX_W-1:0]      chain_best [PALETTE_SIZE];
   dist_type              chain_best_dist [PALETTE_SIZE];
   dist_type              chain_dist [PALETTE_SIZE][PALETTE_SIZE];

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   pixel_type             chosen;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= GAINS_RESET;
         count_ff <= COUNT_RESET;
         for (int i = 0; i < PALETTE_SIZE; i++) begin
            entries_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_GAINS) begin
            gains_ff <= csr_wdata;
         end
         if (csr_index == CSR_COUNT) begin
            count_ff <= csr_wdata[IDX_W-1:0];
         end
         for (int i = 0; i < PALETTE_SIZE; i++) begin
            if (csr_index == CSR_INDEX_W'(int'(CSR_ENTRY0) + i)) begin
               entries_ff[i] <= csr_wdata[$bits(pixel_type)-1:0];
            end
         end
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         count_used = IDX_W'(1);
      end else if (count_ff > IDX_W'(PALETTE_SIZE)) begin
         count_used = IDX_W'(PALETTE_SIZE);
      end else begin
         count_used = count_ff;
      end
   end

   npcq_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .gains     (gains_ff),
      .out_valid (scale_valid),
      .out_ready (scale_ready),
      .out_pixel (scale_pixel)
   );

   npcq_dist #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scale_valid),
      .in_ready  (scale_ready),
      .in_pixel  (scale_pixel),
      .entries   (entries_ff),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_dist  (chain_dist[0])
   );

   assign chain_best[0] = '0;
   assign chain_best_dist[0] = chain_dist[0][0];

   for (genvar k = 1; k < PALETTE_SIZE; k++) begin : g_cmp
      npcq_cmp_stage #(
         .PALETTE_SIZE (PALETTE_SIZE),
         .STAGE        (k)
      ) u_cmp (
         .clock         (clock),
         .reset         (reset),
         .count         (count_used),
         .in_valid      (chain_valid[k-1]),
         .in_ready      (chain_ready[k-1]),
         .in_best       (chain_best[k-1]),
         .in_best_dist  (chain_best_dist[k-1]),
         .in_dist       (chain_dist[k-1]),
         .out_valid     (chain_valid[k]),
         .out_ready     (chain_ready[k]),
         .out_best      (chain_best[k]),
         .out_best_dist (chain_best_dist[k]),
         .out_dist      (chain_dist[k])
      );
   end

   assign chain_ready[PALETTE_SIZE-1] = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = chain_ready[PALETTE_SIZE-1] ? chain_valid[PALETTE_SIZE-1] : rsp_valid_ff;
   assign chosen = entries_ff[chain_best[PALETTE_SIZE-1][EW-1:0]];

   always_comb begin
      rsp_in.palette_index = chain_best[PALETTE_SIZE-1];
      rsp_in.out_red = chosen.red;
      rsp_in.out_green = chosen.green;
      rsp_in.out_blue = chosen.blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ready[PALETTE_SIZE-1] && chain_valid[PALETTE_SIZE-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_index_in_use: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.palette_index < count_used)
      else $error("result index lies beyond the entries in use");

   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the output side is free");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present right after reset");

endmodule

`default_nettype wire

// File: dv/nearest_palette_color_quantizer_unit_test.sv
// Self-checking testbench for the nearest palette color quantizer: predicted colors vs. DUT beats.
`timescale 1ns / 1ps

module nearest_palette_color_quantizer_unit_test;
   import npcq_pkg::*;

   typedef enum {PIX_RANDOM, PIX_NEAR, PIX_EXTREME} pixel_kind;

   class nearest_color_board;
      logic [CSR_DATA_W-1:0] gains;
      logic [IDX_W-1:0]      entry_count;
      logic [23:0]           entries [6];
      rsp_type               expected_colors [$];
      int                    failures;

      function new();
         gains = GAINS_RESET;
         entry_count = COUNT_RESET;
         foreach (entries[k]) entries[k] = '0;
         failures = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         if (index == CSR_GAINS) begin
            gains = data;
         end else if (index == CSR_COUNT) begin
            entry_count = data[IDX_W-1:0];
         end else if (index >= CSR_ENTRY0) begin
            entries[index - CSR_ENTRY0] = data[23:0];
         end
      endfunction

      function int scaled(logic [CHAN_W-1:0] level, logic [GAIN_W-1:0] gain);
         int product;
         product = (int'(level) * int'(gain)) >>> 8;
         return (product > 255) ? 255 : product;
      endfunction

      function rsp_type nearest_color(req_type px);
         int      level [3];
         int      count;
         int      distance;
         int      best_dist;
         int      best;
         int      diff;
         rsp_type color;
         level[0] = scaled(px.in_red, gains[29:20]);
         level[1] = scaled(px.in_green, gains[19:10]);
         level[2] = scaled(px.in_blue, gains[9:0]);
         count = int'(entry_count);
         if (count < 1) count = 1;
         if (count > 6) count = 6;
         best = 0;
         best_dist = 0;
         for (int k = 0; k < count; k++) begin
            distance = 0;
            for (int ch = 0; ch < 3; ch++) begin
               diff = level[ch] - int'(entries[k][(2 - ch) * 8 +: 8]);
               distance += diff * diff;
            end
            if (k == 0 || distance < best_dist) begin
               best_dist = distance;
               best = k;
            end
         end
         color.palette_index = IDX_W'(best);
         color.out_red = entries[best][23:16];
         color.out_green = entries[best][15:8];
         color.out_blue = entries[best][7:0];
         return color;
      endfunction

      function void note_pixel(req_type px);
         expected_colors = {expected_colors, nearest_color(px)};
      endfunction

      function void report_mismatch(string field, logic [7:0] want, logic [7:0] got);
         failures++;
         $display("%0t mismatch on %s: expected %0h actual %0h", $time, field, want, got);
      endfunction

      function void check_color(rsp_type got);
         rsp_type want;
         if (expected_colors.size() == 0) begin
            failures++;
            $display("%0t unexpected beat: expected none, actual index %0h color %h",
                     $time, got.palette_index, {got.out_red, got.out_green, got.out_blue});
            return;
         end
         want = expected_colors.pop_front();
         if (got.palette_index !== want.palette_index)
            report_mismatch("palette_index", 8'(want.palette_index), 8'(got.palette_index));
         if (got.out_red !== want.out_red)
            report_mismatch("out_red", want.out_red, got.out_red);
         if (got.out_green !== want.out_green)
            report_mismatch("out_green", want.out_green, got.out_green);
         if (got.out_blue !== want.out_blue)
            report_mismatch("out_blue", want.out_blue, got.out_blue);
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_GAINS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   nearest_color_board     board = new();
   logic [CSR_DATA_W-1:0]  entry_words [6];
   int                     send_idle_pct = 26;
   int                     recv_idle_pct = 57;
   int                     hold_request = 0;

   nearest_palette_color_quantizer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready) board.check_color(rsp_data);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_pixel(input req_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (!req_ready);
      board.note_pixel(px);
   endtask

   task automatic wait_for_colors();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic program_registers(input logic [CSR_DATA_W-1:0] gains_word,
                                    input logic [CSR_DATA_W-1:0] count_word);
      logic [CSR_INDEX_W-1:0] index;
      csr_we <= 1'b1;
      csr_index <= CSR_GAINS;
      csr_wdata <= gains_word;
      @(posedge clock);
      board.write_register(CSR_GAINS, gains_word);
      csr_index <= CSR_COUNT;
      csr_wdata <= count_word;
      @(posedge clock);
      board.write_register(CSR_COUNT, count_word);
      for (int k = 0; k < 6; k++) begin
         index = CSR_ENTRY0 + CSR_INDEX_W'(k);
         csr_index <= index;
         csr_wdata <= entry_words[k];
         @(posedge clock);
         board.write_register(index, entry_words[k]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [23:0] nudge_color(logic [23:0] base, int spread);
      logic [23:0] color;
      int          level;
      for (int ch = 0; ch < 3; ch++) begin
         level = int'(base[ch * 8 +: 8]) + int'($urandom_range(2 * spread)) - spread;
         if (level < 0) level = 0;
         if (level > 255) level = 255;
         color[ch * 8 +: 8] = 8'(level);
      end
      return color;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_gains();
      logic [CSR_DATA_W-1:0] word;
      int                    pick;
      for (int ch = 0; ch < 3; ch++) begin
         pick = $urandom_range(99);
         if (pick < 35) word[ch * 10 +: 10] = 10'h100;
         else if (pick < 45) word[ch * 10 +: 10] = 10'h000;
         else if (pick < 55) word[ch * 10 +: 10] = 10'h3FF;
         else if (pick < 75) word[ch * 10 +: 10] = 10'($urandom_range(320, 192));
         else word[ch * 10 +: 10] = 10'($urandom);
      end
      return word;
   endfunction

   task automatic program_random_palette();
      logic [23:0] color;
      int          pick;
      for (int k = 0; k < 6; k++) begin
         pick = $urandom_range(99);
         if (k > 0 && pick < 15) color = entry_words[k - 1][23:0];
         else if (k > 0 && pick < 35) color = nudge_color(entry_words[k - 1][23:0], 4);
         else color = 24'($urandom);
         entry_words[k] = {6'($urandom), color};
      end
      program_registers(random_gains(), {27'($urandom), 3'($urandom_range(7))});
   endtask

   function automatic req_type random_pixel();
      logic [23:0] color;
      pixel_kind   kind;
      kind = pixel_kind'($urandom_range(2));
      case (kind)
         PIX_NEAR: begin
            color = nudge_color(board.entries[$urandom_range(5)], $urandom_range(8));
         end
         PIX_EXTREME: begin
            for (int ch = 0; ch < 3; ch++)
               color[ch * 8 +: 8] = ($urandom_range(2) == 0) ? 8'($urandom) :
                                    ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
         end
         default: begin
            color = 24'($urandom);
         end
      endcase
      return color;
   endfunction

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Palette after reset is all black, so every pixel maps to entry 0.
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h5AA55A);
      wait_for_colors();

      entry_words = '{30'h3F000000, 30'h00FFFFFF, 30'h15FF0000,
                      30'h0000FF00, 30'h000000FF, 30'h2A808080};
      program_registers(GAINS_RESET, 30'd6);
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFF0000);
      send_pixel(24'h00FF00);
      send_pixel(24'h0000FF);
      send_pixel(24'h808080);
      send_pixel(24'h7F7F7F);
      // Equidistant from black and mid gray; the lower index has to win.
      send_pixel(24'h404040);
      send_pixel(24'hAA55AA);
      send_pixel(24'h55AA55);
      wait_for_colors();

      // Maximum gains saturate the brighter pixels; a count of seven is clamped to six.
      program_registers(30'h3FFFFFFF, 30'h2AAAAAAF);
      send_pixel(24'h808080);
      send_pixel(24'h010101);
      send_pixel(24'hFFFFFF);
      wait_for_colors();

      // Zero gains and a count of zero, which leaves only entry 0 in play.
      entry_words = '{30'h00102030, 30'h00FFFFFF, 30'h00FFFFFF,
                      30'h00000000, 30'h00FFFFFF, 30'h00000000};
      program_registers(30'h00000000, 30'h15555550);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      wait_for_colors();

      // Mixed gains against duplicate entries; the first duplicate wins.
      entry_words = '{30'h00000000, 30'h00FF0080, 30'h00FF0080,
                      30'h00FFFFFF, 30'h00800000, 30'h00FF0080};
      program_registers({10'h3FF, 10'h000, 10'h100}, 30'd6);
      send_pixel(24'h40C080);
      send_pixel(24'h010203);
      wait_for_colors();

      // Long receiver stall with back-to-back beats, so the pipeline backs up.
      send_idle_pct = 0;
      hold_request = 60;
      repeat (40) send_pixel(random_pixel());
      wait_for_colors();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 57 : 0;
         recv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 26 : 0;
         repeat (6) begin
            program_random_palette();
            repeat (75) send_pixel(random_pixel());
            wait_for_colors();
         end
      end

      repeat (12) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: nearest_palette_color_quantizer_unit.f
hdl/npcq_pkg.sv
hdl/npcq_scale.sv
hdl/npcq_dist.sv
hdl/npcq_cmp_stage.sv
hdl/nearest_palette_color_quantizer_unit.sv
dv/nearest_palette_color_quantizer_unit_test.sv
